/* rtl/disparity_map_max_splat_core_assert.svh */
// Assertion macros used by the RTL of the disparity map core.
`ifndef DISPARITY_MAP_MAX_SPLAT_CORE_ASSERT_SVH
`define DISPARITY_MAP_MAX_SPLAT_CORE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge outside reset.
`define DMMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmms assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DMMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmms assertion failed");

`else

`define DMMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DMMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/dmms_pkg.sv */
package dmms_pkg;

    // Store geometry.
    localparam int MAX_MAP_WIDTH  = 128;
    localparam int MAX_MAP_HEIGHT = 128;
    localparam int COORD_BITS     = 11;

    localparam int CELL_COUNT = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // Fixed field widths of the ports.
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int MAP_DIM_W     = 8;
    localparam int IMG_DIM_W     = 12;
    localparam int FIELD_COORD_W = 11;
    localparam int INDEX_W       = 14;
    localparam int DISP_W        = 12;

    // Coordinate bits actually used from each coordinate field.
    localparam int COORD_W = (COORD_BITS < FIELD_COORD_W) ? COORD_BITS : FIELD_COORD_W;

    // Divider sizing: numerator is 2*coord*map_dim + image_dim.
    localparam int NUM_W     = COORD_W + MAP_DIM_W + 2;
    localparam int DEN_W     = IMG_DIM_W + 1;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    // Cell index before truncation: row * width + column.
    localparam int IDX_WIDE_W = 2 * MAP_DIM_W + 1;

    // Disparity limits and the invalid cell code.
    localparam int DISP_LIMIT = 2047;
    localparam logic signed [DISP_W-1:0] INVALID_CODE = {1'b1, {(DISP_W-1){1'b0}}};

    // Request codes.
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_SPLAT = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Status codes.
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_RAISED  = 2'd1;
    localparam logic [1:0] STATUS_KEPT    = 2'd2;
    localparam logic [1:0] STATUS_DROPPED = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    // Configuration reset values.
    localparam logic [MAP_DIM_W-1:0] MAP_WIDTH_RST    = 8'd128;
    localparam logic [MAP_DIM_W-1:0] MAP_HEIGHT_RST   = 8'd128;
    localparam logic [IMG_DIM_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [IMG_DIM_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

endpackage

/* rtl/dmms_ram.sv */
module dmms_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/disparity_map_max_splat_core.sv */
// Disparity map with max splatting. The map lives in one single-port-write,
// registered-read RAM of MAX_MAP_WIDTH x MAX_MAP_HEIGHT cells (16384 by
// default). Items are handled one at a time; in_stall is low only while the
// core is idle. For a point word the two cell coordinates come from a pair of
// restoring dividers that retire one quotient bit per cycle, followed by a
// read-modify-write of the cell. A clear word sweeps the RAM one cell per
// cycle. After reset the same sweep runs once, with no result, before the
// first input word is accepted; configuration writes are taken throughout.
// A finished result sits in the output register while the next input word is
// accepted.
`include "disparity_map_max_splat_core_assert.svh"

module disparity_map_max_splat_core
    import dmms_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration write port.
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    // Input channel.
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  req_type,
    input  logic [FIELD_COORD_W-1:0]    left_x,
    input  logic [FIELD_COORD_W-1:0]    right_x,
    input  logic [FIELD_COORD_W-1:0]    right_y,
    input  logic [INDEX_W-1:0]          read_index,
    // Output channel.
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [INDEX_W-1:0]          cell_index,
    output logic                        cell_valid,
    output logic signed [DISP_W-1:0]    cell_disparity
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CLEAR  = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_DIV    = 8'b0000_1000,
        S_ADDR   = 8'b0001_0000,
        S_RDREQ  = 8'b0010_0000,
        S_RDDATA = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    // Control registers.
    state_t                 state_reg, state_next;
    logic                   boot_reg, boot_next;
    logic [ADDR_W-1:0]      clear_ptr_reg, clear_ptr_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   out_valid_reg, out_valid_next;

    // Configuration registers.
    logic [MAP_DIM_W-1:0]   map_width_reg, map_width_next;
    logic [MAP_DIM_W-1:0]   map_height_reg, map_height_next;
    logic [IMG_DIM_W-1:0]   image_width_reg, image_width_next;
    logic [IMG_DIM_W-1:0]   image_height_reg, image_height_next;

    // Working payload registers.
    logic [1:0]             req_reg, req_next;
    logic [COORD_W-1:0]     rx_reg, rx_next;
    logic [COORD_W-1:0]     ry_reg, ry_next;
    logic signed [DISP_W-1:0] disp_reg, disp_next;
    logic [NUM_W-1:0]       num_x_reg, num_x_next;
    logic [NUM_W-1:0]       num_y_reg, num_y_next;
    logic [DEN_W-1:0]       den_x_reg, den_x_next;
    logic [DEN_W-1:0]       den_y_reg, den_y_next;
    logic [DEN_W-1:0]       rem_x_reg, rem_x_next;
    logic [DEN_W-1:0]       rem_y_reg, rem_y_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;

    // Pending result.
    logic [1:0]             res_status_reg, res_status_next;
    logic [INDEX_W-1:0]     res_index_reg, res_index_next;
    logic                   res_valid_reg, res_valid_next;
    logic signed [DISP_W-1:0] res_disp_reg, res_disp_next;

    // Output register.
    logic [1:0]             status_reg, status_next;
    logic [INDEX_W-1:0]     cell_index_reg, cell_index_next;
    logic                   cell_valid_reg, cell_valid_next;
    logic signed [DISP_W-1:0] cell_disparity_reg, cell_disparity_next;

    // Combinational helpers.
    logic                   in_accept;
    logic [MAP_DIM_W-1:0]   w_eff;
    logic [MAP_DIM_W-1:0]   h_eff;
    logic [COORD_W-1:0]     lx_c;
    logic [COORD_W-1:0]     rx_c;
    logic signed [COORD_W:0] disp_raw;
    int                     disp_int;
    logic [DEN_W:0]         trial_x;
    logic [DEN_W:0]         trial_y;
    logic                   ge_x;
    logic                   ge_y;
    logic [IDX_WIDE_W-1:0]  idx_wide;
    logic signed [DISP_W-1:0] old_disp;

    // RAM port signals.
    logic                   ram_wr_en;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [DISP_W-1:0]      ram_wr_data;
    logic                   ram_rd_en;
    logic [DISP_W-1:0]      ram_rd_data;

    dmms_ram #(
        .WIDTH (DISP_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Effective map size, limited by the store geometry.
    assign w_eff = (int'(map_width_reg) < MAX_MAP_WIDTH) ? map_width_reg
                                                         : MAP_DIM_W'(MAX_MAP_WIDTH);
    assign h_eff = (int'(map_height_reg) < MAX_MAP_HEIGHT) ? map_height_reg
                                                           : MAP_DIM_W'(MAX_MAP_HEIGHT);

    // Saturated disparity of the incoming word.
    assign lx_c     = left_x[COORD_W-1:0];
    assign rx_c     = right_x[COORD_W-1:0];
    assign disp_raw = $signed({1'b0, lx_c}) - $signed({1'b0, rx_c});

    always_comb
    begin
        disp_int = int'(disp_raw);
        if (disp_int > DISP_LIMIT)
        begin
            disp_int = DISP_LIMIT;
        end
        if (disp_int < -DISP_LIMIT)
        begin
            disp_int = -DISP_LIMIT;
        end
    end

    // One restoring division step for column and row.
    assign trial_x = {rem_x_reg, num_x_reg[NUM_W-1]};
    assign trial_y = {rem_y_reg, num_y_reg[NUM_W-1]};
    assign ge_x    = (trial_x >= {1'b0, den_x_reg});
    assign ge_y    = (trial_y >= {1'b0, den_y_reg});

    // Cell index from the quotients.
    assign idx_wide = IDX_WIDE_W'(num_y_reg[MAP_DIM_W-1:0]) * IDX_WIDE_W'(w_eff)
                    + IDX_WIDE_W'(num_x_reg[MAP_DIM_W-1:0]);

    assign old_disp = $signed(ram_rd_data);

    // Next-state and datapath logic.
    always_comb
    begin
        state_next          = state_reg;
        boot_next           = boot_reg;
        clear_ptr_next      = clear_ptr_reg;
        div_cnt_next        = div_cnt_reg;
        out_valid_next      = out_valid_reg && out_stall;
        map_width_next      = map_width_reg;
        map_height_next     = map_height_reg;
        image_width_next    = image_width_reg;
        image_height_next   = image_height_reg;
        req_next            = req_reg;
        rx_next             = rx_reg;
        ry_next             = ry_reg;
        disp_next           = disp_reg;
        num_x_next          = num_x_reg;
        num_y_next          = num_y_reg;
        den_x_next          = den_x_reg;
        den_y_next          = den_y_reg;
        rem_x_next          = rem_x_reg;
        rem_y_next          = rem_y_reg;
        addr_next           = addr_reg;
        res_status_next     = res_status_reg;
        res_index_next      = res_index_reg;
        res_valid_next      = res_valid_reg;
        res_disp_next       = res_disp_reg;
        status_next         = status_reg;
        cell_index_next     = cell_index_reg;
        cell_valid_next     = cell_valid_reg;
        cell_disparity_next = cell_disparity_reg;
        ram_wr_en           = 1'b0;
        ram_wr_addr         = addr_reg;
        ram_wr_data         = disp_reg;
        ram_rd_en           = 1'b0;

        // The user keeps configuration writes to idle; the core does not enforce it.
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MAP_WIDTH:    map_width_next    = cfg_data[MAP_DIM_W-1:0];
                CFG_MAP_HEIGHT:   map_height_next   = cfg_data[MAP_DIM_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_next  = cfg_data[IMG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_next = cfg_data[IMG_DIM_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    req_next        = req_type;
                    rx_next         = rx_c;
                    ry_next         = right_y[COORD_W-1:0];
                    disp_next       = DISP_W'(disp_int);
                    res_status_next = STATUS_DONE;
                    res_index_next  = '0;
                    res_valid_next  = 1'b0;
                    res_disp_next   = '0;
                    case (req_type)
                        REQ_CLEAR:
                        begin
                            clear_ptr_next = '0;
                            state_next     = S_CLEAR;
                        end
                        REQ_SPLAT:
                        begin
                            state_next = S_MUL;
                        end
                        REQ_READ:
                        begin
                            res_index_next = read_index;
                            addr_next      = ADDR_W'(read_index);
                            if (int'(read_index) >= CELL_COUNT)
                            begin
                                res_status_next = STATUS_DROPPED;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_RDREQ;
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            // Sweep the whole store with the invalid code.
            S_CLEAR:
            begin
                ram_wr_en      = 1'b1;
                ram_wr_addr    = clear_ptr_reg;
                ram_wr_data    = INVALID_CODE;
                clear_ptr_next = clear_ptr_reg + 1'b1;
                if (clear_ptr_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    clear_ptr_next = '0;
                    boot_next      = 1'b0;
                    state_next     = boot_reg ? S_IDLE : S_EMIT;
                end
            end

            // Build the rounding numerators and denominators.
            S_MUL:
            begin
                num_x_next   = NUM_W'({NUM_W'(rx_reg) * NUM_W'(w_eff), 1'b0})
                             + NUM_W'(image_width_reg);
                num_y_next   = NUM_W'({NUM_W'(ry_reg) * NUM_W'(h_eff), 1'b0})
                             + NUM_W'(image_height_reg);
                den_x_next   = {image_width_reg, 1'b0};
                den_y_next   = {image_height_reg, 1'b0};
                rem_x_next   = '0;
                rem_y_next   = '0;
                div_cnt_next = '0;
                if (image_width_reg == '0 || image_height_reg == '0)
                begin
                    res_status_next = STATUS_DROPPED;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end

            // One quotient bit per cycle; the numerators become the quotients.
            S_DIV:
            begin
                rem_x_next   = ge_x ? DEN_W'(trial_x - {1'b0, den_x_reg}) : DEN_W'(trial_x);
                rem_y_next   = ge_y ? DEN_W'(trial_y - {1'b0, den_y_reg}) : DEN_W'(trial_y);
                num_x_next   = {num_x_reg[NUM_W-2:0], ge_x};
                num_y_next   = {num_y_reg[NUM_W-2:0], ge_y};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(NUM_W - 1))
                begin
                    state_next = S_ADDR;
                end
            end

            // Range check and cell address.
            S_ADDR:
            begin
                if (num_x_reg >= NUM_W'(w_eff) || num_y_reg >= NUM_W'(h_eff))
                begin
                    res_status_next = STATUS_DROPPED;
                    state_next      = S_EMIT;
                end
                else
                begin
                    addr_next      = ADDR_W'(idx_wide);
                    res_index_next = INDEX_W'(idx_wide);
                    state_next     = S_RDREQ;
                end
            end

            S_RDREQ:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_RDDATA;
            end

            // The write-back lands before the next item can read, so no
            // forwarding is needed.
            S_RDDATA:
            begin
                if (req_reg == REQ_READ)
                begin
                    res_status_next = STATUS_DONE;
                    res_valid_next  = (old_disp != INVALID_CODE);
                    res_disp_next   = (old_disp != INVALID_CODE) ? old_disp : '0;
                end
                else if (old_disp < disp_reg)
                begin
                    ram_wr_en       = 1'b1;
                    ram_wr_addr     = addr_reg;
                    ram_wr_data     = disp_reg;
                    res_status_next = STATUS_RAISED;
                    res_valid_next  = 1'b1;
                    res_disp_next   = disp_reg;
                end
                else
                begin
                    res_status_next = STATUS_KEPT;
                    res_valid_next  = 1'b1;
                    res_disp_next   = old_disp;
                end
                state_next = S_EMIT;
            end

            // Hand the result to the output register once it is free.
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    status_next         = res_status_reg;
                    cell_index_next     = res_index_reg;
                    cell_valid_next     = res_valid_reg;
                    cell_disparity_next = res_disp_reg;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            boot_reg         <= 1'b1;
            clear_ptr_reg    <= '0;
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
            map_width_reg    <= MAP_WIDTH_RST;
            map_height_reg   <= MAP_HEIGHT_RST;
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else
        begin
            state_reg        <= state_next;
            boot_reg         <= boot_next;
            clear_ptr_reg    <= clear_ptr_next;
            div_cnt_reg      <= div_cnt_next;
            out_valid_reg    <= out_valid_next;
            map_width_reg    <= map_width_next;
            map_height_reg   <= map_height_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg            <= req_next;
        rx_reg             <= rx_next;
        ry_reg             <= ry_next;
        disp_reg           <= disp_next;
        num_x_reg          <= num_x_next;
        num_y_reg          <= num_y_next;
        den_x_reg          <= den_x_next;
        den_y_reg          <= den_y_next;
        rem_x_reg          <= rem_x_next;
        rem_y_reg          <= rem_y_next;
        addr_reg           <= addr_next;
        res_status_reg     <= res_status_next;
        res_index_reg      <= res_index_next;
        res_valid_reg      <= res_valid_next;
        res_disp_reg       <= res_disp_next;
        status_reg         <= status_next;
        cell_index_reg     <= cell_index_next;
        cell_valid_reg     <= cell_valid_next;
        cell_disparity_reg <= cell_disparity_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign cell_index     = cell_index_reg;
    assign cell_valid     = cell_valid_reg;
    assign cell_disparity = cell_disparity_reg;

    // The RAM is written only by the clear sweep or a raising write-back.
    `DMMS_ASSERT_IMPLY(a_wr_source, clk, rst_n, ram_wr_en, (state_reg == S_CLEAR || state_reg == S_RDDATA))

    // A write-back always stores a strictly larger disparity than it read.
    `DMMS_ASSERT_IMPLY(a_wr_larger, clk, rst_n, (ram_wr_en && state_reg == S_RDDATA), ($signed(ram_wr_data) > $signed(ram_rd_data)))

    // The clear pointer is back at zero whenever the core is idle.
    `DMMS_ASSERT_IMPLY(a_ptr_idle, clk, rst_n, (state_reg == S_IDLE), (clear_ptr_reg == '0))

    // An accepted clear word starts the sweep in the next cycle.
    `DMMS_ASSERT_NEXT(a_clear_start, clk, rst_n, (in_accept && req_type == REQ_CLEAR), (state_reg == S_CLEAR))

endmodule

/* test/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dmms_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int RESET_CYCLES = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_LIMIT = 10;
    localparam longint TIMEOUT_NS = 64'd1_000_000 * CLK_PERIOD;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]               status;
        logic [INDEX_W-1:0]       index;
        logic                     valid;
        logic signed [DISP_W-1:0] disparity;
    } cell_result_t;

    // One request word; typed marks a row whose expected result is written out.
    typedef struct packed {
        logic [1:0]               req;
        logic [FIELD_COORD_W-1:0] lx;
        logic [FIELD_COORD_W-1:0] rx;
        logic [FIELD_COORD_W-1:0] ry;
        logic [INDEX_W-1:0]       ridx;
        logic                     typed;
        cell_result_t             want;
    } map_request_t;

    // One map setting and the traffic shape used while it is in force.
    typedef struct packed {
        logic [MAP_DIM_W-1:0] mw;
        logic [MAP_DIM_W-1:0] mh;
        logic [IMG_DIM_W-1:0] iw;
        logic [IMG_DIM_W-1:0] ih;
        logic [15:0]          word_count;
        logic [7:0]           gap_pct;
        logic [7:0]           stall_pct;
        logic                 sweep_first;
        logic                 hold;
    } map_setting_t;

    localparam cell_result_t NO_CELL = '{STATUS_DONE, '0, 1'b0, '0};
    localparam cell_result_t DROPPED_CELL = '{STATUS_DROPPED, '0, 1'b0, '0};
    localparam cell_result_t UNSET_LAST = '{STATUS_DONE, INDEX_W'(CELL_COUNT - 1), 1'b0, '0};
    localparam cell_result_t UNSET_129 = '{STATUS_DONE, INDEX_W'(129), 1'b0, '0};

    localparam int DIRECTED_COUNT = 18;
    localparam int SETTING_COUNT = 10;

    // Opening words at the reset setting (128 x 128 map, 640 x 480 image).
    map_request_t directed_words [DIRECTED_COUNT] = '{
        '{REQ_READ,   11'd0,    11'd0,    11'd0,    14'd0,     1'b1, NO_CELL},
        '{REQ_READ,   11'd0,    11'd0,    11'd0,    14'd16383, 1'b1, UNSET_LAST},
        '{REQ_UNUSED, 11'd2047, 11'd2047, 11'd2047, 14'd16383, 1'b1, NO_CELL},
        '{REQ_SPLAT,  11'd100,  11'd0,    11'd0,    14'd0,     1'b0, NO_CELL},
        '{REQ_SPLAT,  11'd100,  11'd0,    11'd0,    14'd0,     1'b0, NO_CELL},
        '{REQ_SPLAT,  11'd50,   11'd0,    11'd0,    14'd0,     1'b0, NO_CELL},
        '{REQ_SPLAT,  11'd0,    11'd2047, 11'd2047, 14'd0,     1'b1, DROPPED_CELL},
        '{REQ_SPLAT,  11'd2047, 11'd0,    11'd479,  14'd0,     1'b1, DROPPED_CELL},
        '{REQ_SPLAT,  11'd2047, 11'd0,    11'd478,  14'd0,     1'b0, NO_CELL},
        '{REQ_SPLAT,  11'd637,  11'd637,  11'd0,    14'd0,     1'b0, NO_CELL},
        '{REQ_SPLAT,  11'd638,  11'd638,  11'd0,    14'd0,     1'b1, DROPPED_CELL},
        '{REQ_SPLAT,  11'd0,    11'd5,    11'd3,    14'd0,     1'b0, NO_CELL},
        '{REQ_READ,   11'd0,    11'd0,    11'd0,    14'd0,     1'b0, NO_CELL},
        '{REQ_READ,   11'd0,    11'd0,    11'd0,    14'd16256, 1'b0, NO_CELL},
        '{REQ_READ,   11'd0,    11'd0,    11'd0,    14'd129,   1'b0, NO_CELL},
        '{REQ_CLEAR,  11'd2047, 11'd2047, 11'd2047, 14'd16383, 1'b1, NO_CELL},
        '{REQ_READ,   11'd0,    11'd0,    11'd0,    14'd0,     1'b1, NO_CELL},
        '{REQ_READ,   11'd0,    11'd0,    11'd0,    14'd129,   1'b1, UNSET_129}
    };

    // Settings walked after the opening words; every register reaches its extremes here but a zero map height.
    map_setting_t setting_plan [SETTING_COUNT] = '{
        '{8'd128, 8'd128, 12'd640,  12'd480,  16'd200, 8'd30, 8'd30, 1'b0, 1'b1},
        '{8'd1,   8'd1,   12'd1,    12'd1,    16'd120, 8'd25, 8'd25, 1'b0, 1'b0},
        '{8'd255, 8'd255, 12'd4095, 12'd4095, 16'd200, 8'd20, 8'd40, 1'b1, 1'b0},
        '{8'd0,   8'd5,   12'd100,  12'd100,  16'd60,  8'd30, 8'd30, 1'b0, 1'b0},
        '{8'd16,  8'd8,   12'd0,    12'd480,  16'd60,  8'd30, 8'd30, 1'b0, 1'b0},
        '{8'd16,  8'd8,   12'd640,  12'd0,    16'd60,  8'd30, 8'd30, 1'b0, 1'b0},
        '{8'd128, 8'd128, 12'd2048, 12'd2048, 16'd200, 8'd0,  8'd0,  1'b1, 1'b0},
        '{8'd3,   8'd200, 12'd50,   12'd2047, 16'd200, 8'd40, 8'd20, 1'b0, 1'b0},
        '{8'd64,  8'd64,  12'd1024, 12'd1024, 16'd250, 8'd30, 8'd30, 1'b1, 1'b0},
        '{8'd64,  8'd48,  12'd640,  12'd480,  16'd250, 8'd0,  8'd0,  1'b1, 1'b0}
    };

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               req_type;
    logic [FIELD_COORD_W-1:0] left_x;
    logic [FIELD_COORD_W-1:0] right_x;
    logic [FIELD_COORD_W-1:0] right_y;
    logic [INDEX_W-1:0]       read_index;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               status;
    logic [INDEX_W-1:0]       cell_index;
    logic                     cell_valid;
    logic signed [DISP_W-1:0] cell_disparity;

    // Mirror of the map and of the setting registers.
    logic signed [DISP_W-1:0] cell_mirror [CELL_COUNT];
    logic [MAP_DIM_W-1:0]     map_cols_reg = MAP_WIDTH_RST;
    logic [MAP_DIM_W-1:0]     map_rows_reg = MAP_HEIGHT_RST;
    logic [IMG_DIM_W-1:0]     image_cols_reg = IMAGE_WIDTH_RST;
    logic [IMG_DIM_W-1:0]     image_rows_reg = IMAGE_HEIGHT_RST;

    cell_result_t pending_results [$];
    int unsigned  gap_pct = 0;
    int unsigned  stall_pct = 0;
    bit           hold_pending = 1'b0;
    int unsigned  fault_count = 0;
    int unsigned  words_checked = 0;
    int unsigned  raised_count = 0;
    int unsigned  kept_count = 0;
    int unsigned  dropped_count = 0;
    int unsigned  sweep_count = 0;

    disparity_map_max_splat_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .left_x         (left_x),
        .right_x        (right_x),
        .right_y        (right_y),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .cell_index     (cell_index),
        .cell_valid     (cell_valid),
        .cell_disparity (cell_disparity)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Computes the result of one word and updates the map mirror.
    function automatic cell_result_t predict_cell_result(input map_request_t r);
        cell_result_t res;
        int unsigned  eff_w;
        int unsigned  eff_h;
        int unsigned  lx;
        int unsigned  rx;
        int unsigned  ry;
        int unsigned  col;
        int unsigned  row;
        int unsigned  idx;
        int           disp;
        int           old;
        res = NO_CELL;
        case (r.req)
            REQ_CLEAR:
            begin
                for (int i = 0; i < CELL_COUNT; i++)
                    cell_mirror[i] = INVALID_CODE;
            end
            REQ_SPLAT:
            begin
                eff_w = (map_cols_reg < MAX_MAP_WIDTH) ? map_cols_reg : MAX_MAP_WIDTH;
                eff_h = (map_rows_reg < MAX_MAP_HEIGHT) ? map_rows_reg : MAX_MAP_HEIGHT;
                lx = r.lx & ((1 << COORD_W) - 1);
                rx = r.rx & ((1 << COORD_W) - 1);
                ry = r.ry & ((1 << COORD_W) - 1);
                disp = int'(lx) - int'(rx);
                if (disp > DISP_LIMIT)
                    disp = DISP_LIMIT;
                if (disp < -DISP_LIMIT)
                    disp = -DISP_LIMIT;
                if (image_cols_reg == 0 || image_rows_reg == 0)
                begin
                    res = DROPPED_CELL;
                end
                else
                begin
                    // Exact rounding, halves up.
                    col = (2 * rx * eff_w + image_cols_reg) / (2 * image_cols_reg);
                    row = (2 * ry * eff_h + image_rows_reg) / (2 * image_rows_reg);
                    if (col >= eff_w || row >= eff_h)
                    begin
                        res = DROPPED_CELL;
                    end
                    else
                    begin
                        idx = row * eff_w + col;
                        old = int'(cell_mirror[idx]);
                        res.index = INDEX_W'(idx);
                        res.valid = 1'b1;
                        if (old < disp)
                        begin
                            cell_mirror[idx] = DISP_W'(disp);
                            res.status = STATUS_RAISED;
                            res.disparity = DISP_W'(disp);
                        end
                        else
                        begin
                            res.status = STATUS_KEPT;
                            res.disparity = DISP_W'(old);
                        end
                    end
                end
            end
            REQ_READ:
            begin
                idx = r.ridx;
                res.index = r.ridx;
                if (idx >= CELL_COUNT)
                begin
                    res.status = STATUS_DROPPED;
                end
                else if (cell_mirror[idx] != INVALID_CODE)
                begin
                    res.valid = 1'b1;
                    res.disparity = cell_mirror[idx];
                end
            end
            default:
            begin
                res = NO_CELL;
            end
        endcase
        return res;
    endfunction

    // Random word: mostly points near the image, some reads, a little noise.
    function automatic map_request_t random_map_request();
        map_request_t r;
        int unsigned  pick;
        int unsigned  span_x;
        int unsigned  span_y;
        int unsigned  cells;
        int           lx;
        r = '0;
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            r.req = REQ_UNUSED;
            r.lx = FIELD_COORD_W'($urandom);
            r.rx = FIELD_COORD_W'($urandom);
            r.ry = FIELD_COORD_W'($urandom);
            r.ridx = INDEX_W'($urandom);
        end
        else if (pick < 75)
        begin
            r.req = REQ_SPLAT;
            r.ridx = INDEX_W'($urandom);
            if ($urandom_range(0, 9) == 0)
            begin
                r.lx = FIELD_COORD_W'($urandom);
                r.rx = FIELD_COORD_W'($urandom);
                r.ry = FIELD_COORD_W'($urandom);
            end
            else
            begin
                // Aim a little past the image edge so dropped points show up too.
                span_x = (image_cols_reg == 0) ? 2048 : image_cols_reg + image_cols_reg / 8 + 1;
                span_y = (image_rows_reg == 0) ? 2048 : image_rows_reg + image_rows_reg / 8 + 1;
                if (span_x > 2048)
                    span_x = 2048;
                if (span_y > 2048)
                    span_y = 2048;
                r.rx = FIELD_COORD_W'($urandom_range(0, span_x - 1));
                r.ry = FIELD_COORD_W'($urandom_range(0, span_y - 1));
                lx = int'(r.rx) + int'($urandom_range(0, 96)) - 16;
                if (lx < 0)
                    lx = 0;
                if (lx > 2047)
                    lx = 2047;
                r.lx = FIELD_COORD_W'(lx);
            end
        end
        else
        begin
            r.req = REQ_READ;
            r.lx = FIELD_COORD_W'($urandom);
            r.rx = FIELD_COORD_W'($urandom);
            r.ry = FIELD_COORD_W'($urandom);
            cells = ((map_cols_reg < MAX_MAP_WIDTH) ? map_cols_reg : MAX_MAP_WIDTH) *
                    ((map_rows_reg < MAX_MAP_HEIGHT) ? map_rows_reg : MAX_MAP_HEIGHT);
            if (cells != 0 && $urandom_range(0, 3) != 0)
                r.ridx = INDEX_W'($urandom_range(0, cells - 1));
            else
                r.ridx = INDEX_W'($urandom);
        end
        return r;
    endfunction

    // Offers one word, waits for it to be taken, and queues its result.
    task automatic offer_word(input map_request_t r);
        cell_result_t want;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r.req;
        left_x <= r.lx;
        right_x <= r.rx;
        right_y <= r.ry;
        read_index <= r.ridx;
        do
            @(posedge clk);
        while (in_stall);
        want = predict_cell_result(r);
        if (r.typed)
            want = r.want;
        if (r.req == REQ_CLEAR)
            sweep_count++;
        pending_results.push_back(want);
    endtask

    // Writes one register; the enable stays high across back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_MAP_WIDTH:    map_cols_reg = data[MAP_DIM_W-1:0];
            CFG_MAP_HEIGHT:   map_rows_reg = data[MAP_DIM_W-1:0];
            CFG_IMAGE_WIDTH:  image_cols_reg = data[IMG_DIM_W-1:0];
            CFG_IMAGE_HEIGHT: image_rows_reg = data[IMG_DIM_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic wait_until_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus: reset, opening words, then one batch of random words per setting.
    initial
    begin
        map_request_t sweep_word;
        map_setting_t s;
        for (int i = 0; i < CELL_COUNT; i++)
            cell_mirror[i] = INVALID_CODE;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MAP_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = REQ_CLEAR;
        left_x = '0;
        right_x = '0;
        right_y = '0;
        read_index = '0;
        setting_plan[8].mw = MAP_DIM_W'($urandom_range(1, 128));
        setting_plan[8].mh = MAP_DIM_W'($urandom_range(1, 128));
        setting_plan[8].iw = IMG_DIM_W'($urandom_range(1, 2048));
        setting_plan[8].ih = IMG_DIM_W'($urandom_range(1, 2048));
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        gap_pct = 20;
        stall_pct = 20;
        for (int i = 0; i < DIRECTED_COUNT; i++)
            offer_word(directed_words[i]);

        sweep_word = '0;
        sweep_word.req = REQ_CLEAR;
        for (int p = 0; p < SETTING_COUNT; p++)
        begin
            s = setting_plan[p];
            in_valid <= 1'b0;
            wait_until_drained();
            write_reg(CFG_MAP_WIDTH, CFG_W'(s.mw));
            write_reg(CFG_MAP_HEIGHT, CFG_W'(s.mh));
            write_reg(CFG_IMAGE_WIDTH, CFG_W'(s.iw));
            write_reg(CFG_IMAGE_HEIGHT, CFG_W'(s.ih));
            cfg_wr_en <= 1'b0;
            gap_pct = s.gap_pct;
            stall_pct = s.stall_pct;
            if (s.hold)
                hold_pending = 1'b1;
            if (s.sweep_first)
                offer_word(sweep_word);
            for (int n = 0; n < s.word_count; n++)
                offer_word(random_map_request());
        end

        in_valid <= 1'b0;
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d words checked over %0d map settings and %0d clears", words_checked,
                 SETTING_COUNT + 1, sweep_count);
        $display("points raised %0d, kept %0d, dropped %0d; %0d mismatches", raised_count,
                 kept_count, dropped_count, fault_count);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off while words keep coming.
    initial
    begin
        int unsigned burst_left;
        burst_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                burst_left = 0;
            end
            else if (stall_pct == 0)
            begin
                out_stall <= 1'b0;
            end
            else if (burst_left != 0)
            begin
                burst_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
                burst_left = $urandom_range(1, 13) - 1;
            end
        end
    end

    // Each result word is matched against the oldest pending expectation.
    always @(posedge clk)
    begin
        cell_result_t got;
        cell_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = '{status, cell_index, cell_valid, cell_disparity};
            words_checked++;
            if (got.status == STATUS_RAISED)
                raised_count++;
            else if (got.status == STATUS_KEPT)
                kept_count++;
            else if (got.status == STATUS_DROPPED)
                dropped_count++;
            if (pending_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected result word: status %0d index %0d valid %0d disp %0d",
                             got.status, got.index, got.valid, got.disparity);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.index !== want.index ||
                    got.valid !== want.valid || got.disparity !== want.disparity)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("mismatch at %0t: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 $realtime, want.status, want.index, want.valid, want.disparity,
                                 got.status, got.index, got.valid, got.disparity);
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results still pending", pending_results.size());
        $display("simulation failed");
        $finish;
    end

endmodule
